// ===== rtl/dvrt_pkg.sv =====
// ----------------------------------------------------------------------------
// dvrt_pkg
// Shared types and constants of the distance-vector route table.
// ----------------------------------------------------------------------------
package dvrt_pkg;

   localparam int NODES            = 32;
   localparam int ID_W             = 5;
   localparam int COST_W           = 8;
   localparam int CSR_IDX_W        = 2;
   localparam int CSR_DATA_W       = 32;
   localparam int SLOTS            = 2 ** ID_W;
   localparam logic [COST_W-1:0] UNREACHABLE_COST = COST_W'(128);
   localparam logic [COST_W-1:0] SILENCE_RESET    = COST_W'(2);
   localparam logic [COST_W-1:0] COUNT_MAX        = '1;

   localparam logic [1:0] ACT_HELLO  = 2'd0;
   localparam logic [1:0] ACT_UPDATE = 2'd1;
   localparam logic [1:0] ACT_DATA   = 2'd2;
   localparam logic [1:0] ACT_TICK   = 2'd3;

   localparam logic [1:0] KIND_BCAST   = 2'd0;
   localparam logic [1:0] KIND_DELIVER = 2'd1;
   localparam logic [1:0] KIND_FORWARD = 2'd2;
   localparam logic [1:0] KIND_RETURN  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_LOCAL_ID       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEIGHBOUR_MASK = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SILENCE_LIMIT  = 2'd2;

   typedef struct packed {
      logic [1:0]        action;
      logic [ID_W-1:0]   sender_node;
      logic [ID_W-1:0]   target_node;
      logic [COST_W-1:0] offered_cost;
   } req_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [ID_W-1:0]   node_id;
      logic [COST_W-1:0] route_cost;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [COST_W-1:0] cost;
      logic [ID_W-1:0]   next_hop;
   } route_type;

   typedef struct packed {
      logic            age;
      logic            hello;
      logic [ID_W-1:0] hello_node;
      logic            drop;
      logic [ID_W-1:0] drop_node;
   } nbr_ctl_type;

   typedef struct packed {
      logic [SLOTS-1:0] up;
      logic [SLOTS-1:0] silent;
   } nbr_stat_type;

endpackage

// ===== rtl/dvrt_ram.sv =====
// ----------------------------------------------------------------------------
// dvrt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dvrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/dvrt_neighbour.sv =====
// ----------------------------------------------------------------------------
// dvrt_neighbour
// Per-node silence counters and up flags, with the silent-neighbour vector.
// ----------------------------------------------------------------------------
module dvrt_neighbour import dvrt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  nbr_ctl_type       ctl,
   input  logic [NODES-1:0]  neighbour_mask,
   input  logic [COST_W-1:0] silence_limit,
   output nbr_stat_type      stat
);

   logic [COST_W-1:0] count_ff [NODES];
   logic [COST_W-1:0] count_in [NODES];
   logic [NODES-1:0]  up_ff, up_in;

   always_comb begin
      for (int e = 0; e < NODES; e++) begin
         count_in[e] = count_ff[e];
         up_in[e]    = up_ff[e];
         if (ctl.age && neighbour_mask[e] && count_ff[e] != COUNT_MAX) begin
            count_in[e] = count_ff[e] + COST_W'(1);
         end
         if (ctl.hello && ctl.hello_node == ID_W'(e)) begin
            count_in[e] = '0;
            up_in[e]    = 1'b1;
         end
         if (ctl.drop && ctl.drop_node == ID_W'(e)) begin
            up_in[e] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff <= '0;
         for (int e = 0; e < NODES; e++) begin
            count_ff[e] <= '0;
         end
      end else begin
         up_ff <= up_in;
         for (int e = 0; e < NODES; e++) begin
            count_ff[e] <= count_in[e];
         end
      end
   end

   always_comb begin
      stat = '0;
      for (int e = 0; e < NODES; e++) begin
         stat.up[e]     = up_ff[e];
         stat.silent[e] = neighbour_mask[e] && (count_ff[e] > silence_limit);
      end
   end

endmodule

// ===== rtl/distance_vector_route_table.sv =====
// ----------------------------------------------------------------------------
// distance_vector_route_table
// Route table of one distance-vector node: hello, update, data and tick.
// ----------------------------------------------------------------------------
// Input words arrive on req_valid/req_ready with a req_type payload; result
// words leave on rsp_valid/rsp_ready with a rsp_type payload, and the last
// word of one input carries last. Registers are written on csr_valid with
// csr_index and csr_data; csr_ready is always high.
// Costs and next hops live in a 32-entry RAM with a registered read port;
// per-entry valid flops make an unwritten entry read as unreachable via 0,
// so no clearing pass is needed and the block is ready right after reset.
// Data packets and short updates pass from S_EXEC straight to S_FINISH. A
// hello to a new neighbour, an improving update or a tick while some neighbour
// is up walks the RAM one entry per cycle, except while a word to emit waits
// for the receiver to raise rsp_ready.
// A new input is taken only after the previous one has produced all of its
// words. One word is held back in a pending register until the next one is
// known, so the last flag is right even when a tick scan ends on a miss.
// Reset clears the state machine, the valid flags, neighbour state and the
// registers; a stalled receiver holds the table walk at the next word to emit.
// ----------------------------------------------------------------------------
module distance_vector_route_table import dvrt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_EXEC    = 7'b0000010,
      S_DUMP_RD = 7'b0000100,
      S_DUMP_EM = 7'b0001000,
      S_SCAN_RD = 7'b0010000,
      S_SCAN_EM = 7'b0100000,
      S_FINISH  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [ID_W-1:0]   local_id_ff;
   logic [NODES-1:0]  mask_ff;
   logic [COST_W-1:0] limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         local_id_ff <= '0;
         mask_ff     <= '0;
         limit_ff    <= SILENCE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LOCAL_ID:       local_id_ff <= csr_data[ID_W-1:0];
            CSR_NEIGHBOUR_MASK: mask_ff     <= csr_data[NODES-1:0];
            CSR_SILENCE_LIMIT:  limit_ff    <= csr_data[COST_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // Item, walk index, result pending and output registers.
   req_type         item_ff, item_in;
   logic [ID_W-1:0] idx_ff, idx_in;
   rsp_type         pend_ff, pend_in;
   logic            pend_valid_ff, pend_valid_in;
   rsp_type         rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [SLOTS-1:0] route_valid_ff, route_valid_in;
   logic            rd_valid_ff, rd_valid_in;

   // RAM ports.
   logic            ram_we, ram_re;
   logic [ID_W-1:0] ram_waddr, ram_raddr;
   route_type       ram_wdata, ram_rdata;

   dvrt_ram #(
      .WIDTH ($bits(route_type)),
      .DEPTH (SLOTS)
   ) u_route_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   nbr_ctl_type  nbr_ctl;
   nbr_stat_type nbr_stat;

   dvrt_neighbour u_neighbour (
      .clock          (clock),
      .reset          (reset),
      .ctl            (nbr_ctl),
      .neighbour_mask (mask_ff),
      .silence_limit  (limit_ff),
      .stat           (nbr_stat)
   );

   // The entry last read; an entry never written reads as unreachable via 0.
   logic [COST_W-1:0] cur_cost;
   logic [ID_W-1:0]   cur_hop;
   assign cur_cost = rd_valid_ff ? ram_rdata.cost : UNREACHABLE_COST;
   assign cur_hop  = rd_valid_ff ? ram_rdata.next_hop : '0;

   logic              out_free, can_emit, emit_go;
   logic [1:0]        emit_kind;
   logic [ID_W-1:0]   emit_node;
   logic [COST_W-1:0] emit_cost;
   logic [COST_W:0]   new_cost;
   logic [COST_W-1:0] sat_cost;
   logic              sender_ok, target_ok, hit;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign can_emit  = !pend_valid_ff || out_free;
   assign sender_ok = 32'(item_ff.sender_node) < NODES;
   assign target_ok = 32'(item_ff.target_node) < NODES;
   assign sat_cost  = (item_ff.offered_cost > UNREACHABLE_COST) ?
                      UNREACHABLE_COST : item_ff.offered_cost;
   assign new_cost  = {1'b0, sat_cost} + (COST_W+1)'(1);
   assign hit       = nbr_stat.silent[idx_ff] || nbr_stat.silent[cur_hop];

   always_comb begin
      state_in       = state_ff;
      item_in        = item_ff;
      idx_in         = idx_ff;
      pend_in        = pend_ff;
      pend_valid_in  = pend_valid_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      route_valid_in = route_valid_ff;
      rd_valid_in    = rd_valid_ff;
      ram_we         = 1'b0;
      ram_waddr      = '0;
      ram_wdata      = '0;
      ram_re         = 1'b0;
      ram_raddr      = '0;
      nbr_ctl        = '0;
      emit_go        = 1'b0;
      emit_kind      = KIND_BCAST;
      emit_node      = '0;
      emit_cost      = '0;
      req_ready      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               item_in   = req_data;
               ram_re    = 1'b1;
               ram_raddr = req_data.target_node;
               state_in  = S_EXEC;
            end
         end

         S_EXEC: begin
            idx_in   = '0;
            state_in = S_FINISH;
            case (item_ff.action)
               ACT_HELLO: begin
                  if (sender_ok) begin
                     ram_we    = 1'b1;
                     ram_waddr = item_ff.sender_node;
                     ram_wdata = '{cost: COST_W'(1), next_hop: item_ff.sender_node};
                     emit_go   = 1'b1;
                     emit_node = item_ff.sender_node;
                     emit_cost = COST_W'(1);
                     if (mask_ff[item_ff.sender_node]) begin
                        nbr_ctl.hello      = 1'b1;
                        nbr_ctl.hello_node = item_ff.sender_node;
                        if (!nbr_stat.up[item_ff.sender_node]) begin
                           state_in = S_DUMP_RD;
                        end
                     end
                  end
               end
               ACT_UPDATE: begin
                  if (sender_ok && target_ok) begin
                     if ({1'b0, cur_cost} > new_cost) begin
                        ram_we    = 1'b1;
                        ram_waddr = item_ff.target_node;
                        ram_wdata = '{cost: new_cost[COST_W-1:0],
                                      next_hop: item_ff.sender_node};
                        state_in  = S_DUMP_RD;
                     end else if (new_cost >= {1'b0, UNREACHABLE_COST}) begin
                        ram_we    = 1'b1;
                        ram_waddr = item_ff.target_node;
                        ram_wdata = '{cost: UNREACHABLE_COST, next_hop: cur_hop};
                        if (cur_cost != UNREACHABLE_COST) begin
                           emit_go   = 1'b1;
                           emit_node = item_ff.target_node;
                           emit_cost = UNREACHABLE_COST;
                        end
                     end
                  end
               end
               ACT_DATA: begin
                  emit_go = 1'b1;
                  if (item_ff.target_node == local_id_ff) begin
                     emit_kind = KIND_DELIVER;
                     emit_node = item_ff.target_node;
                  end else if (target_ok && 32'(cur_hop) < NODES && mask_ff[cur_hop]) begin
                     emit_kind = KIND_FORWARD;
                     emit_node = cur_hop;
                     emit_cost = cur_cost;
                  end else begin
                     emit_kind = KIND_RETURN;
                     emit_node = item_ff.sender_node;
                  end
               end
               ACT_TICK: begin
                  nbr_ctl.age = 1'b1;
                  if (|nbr_stat.up) begin
                     state_in = S_SCAN_RD;
                  end
               end
               default: ;
            endcase
         end

         S_DUMP_RD, S_SCAN_RD: begin
            ram_re    = 1'b1;
            ram_raddr = idx_ff;
            state_in  = (state_ff == S_DUMP_RD) ? S_DUMP_EM : S_SCAN_EM;
         end

         S_DUMP_EM, S_SCAN_EM: begin
            if (state_ff == S_SCAN_EM && !hit) begin
               emit_go = 1'b0;
            end else begin
               emit_go   = can_emit;
               emit_node = idx_ff;
               emit_cost = (state_ff == S_SCAN_EM) ? UNREACHABLE_COST : cur_cost;
            end
            if (state_ff == S_SCAN_EM && hit && can_emit) begin
               ram_we            = 1'b1;
               ram_waddr         = idx_ff;
               ram_wdata         = '{cost: UNREACHABLE_COST, next_hop: cur_hop};
               nbr_ctl.drop      = 1'b1;
               nbr_ctl.drop_node = idx_ff;
            end
            if (emit_go || (state_ff == S_SCAN_EM && !hit)) begin
               if (idx_ff == ID_W'(NODES - 1)) begin
                  state_in = S_FINISH;
               end else begin
                  idx_in    = idx_ff + ID_W'(1);
                  ram_re    = 1'b1;
                  ram_raddr = idx_ff + ID_W'(1);
               end
            end
         end

         S_FINISH: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_in        = pend_ff;
               rsp_in.last   = 1'b1;
               rsp_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      // A new result word pushes the held one out and takes its place.
      if (emit_go) begin
         if (pend_valid_ff) begin
            rsp_in       = pend_ff;
            rsp_valid_in = 1'b1;
         end
         pend_in       = '{kind: emit_kind, node_id: emit_node,
                           route_cost: emit_cost, last: 1'b0};
         pend_valid_in = 1'b1;
      end

      if (ram_we) begin
         route_valid_in[ram_waddr] = 1'b1;
      end
      if (ram_re) begin
         rd_valid_in = route_valid_ff[ram_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         route_valid_ff <= '0;
         rd_valid_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         route_valid_ff <= route_valid_in;
         rd_valid_ff    <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      idx_ff  <= idx_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
